// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the region table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/artl_pkg.sv =====
// ----------------------------------------------------------------------------
// artl_pkg
// types, codes and sizes shared by the address region table
// ----------------------------------------------------------------------------
`default_nettype none

package artl_pkg;

   // table size and derived widths
   localparam int MaxRegions = 16;
   localparam int SlotW      = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
   localparam int CountW     = $clog2(MaxRegions + 1);

   // transaction modes
   localparam logic [1:0] ModeInsert  = 2'd0;
   localparam logic [1:0] ModeLookup  = 2'd1;
   localparam logic [1:0] ModeRelease = 2'd2;
   localparam logic [1:0] ModeFlush   = 2'd3;

   // result status codes
   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusDuplicate = 2'd1;
   localparam logic [1:0] StatusFull      = 2'd2;
   localparam logic [1:0] StatusNone      = 2'd1;
   localparam logic [1:0] StatusBusy      = 2'd2;
   localparam logic [1:0] StatusUnlocked  = 2'd1;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] region_index;
      logic [63:0]        region_base;
      logic [63:0]        region_length;
      logic [63:0]        access_address;
      logic [31:0]        access_len;
      logic [3:0]         release_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         slot;
      logic signed [31:0] matched_index;
   } rsp_type;

   // one stored region
   typedef struct packed {
      logic signed [31:0] index;
      logic [63:0]        base;
      logic [63:0]        length;
   } entry_type;

   // outcome of checking one entry
   typedef struct packed {
      logic index_hit;
      logic covers;
   } match_type;

endpackage

`default_nettype wire

// ===== src/artl_match.sv =====
// ----------------------------------------------------------------------------
// artl_match
// shared compare unit: checks one stored region against the transaction
// ----------------------------------------------------------------------------
`default_nettype none

module artl_match (
   input  artl_pkg::entry_type  entry,
   input  logic signed [31:0]   key_index,
   input  logic [63:0]          access_address,
   input  logic [63:0]          access_top,
   output artl_pkg::match_type  result
);

   logic [63:0] region_top;

   // end of region, wrapping modulo 2^64
   assign region_top = entry.base + entry.length;

   // duplicate index and range coverage
   assign result.index_hit = (entry.index == key_index);
   assign result.covers    = (entry.base <= access_address) && (region_top >= access_top);

endmodule

`default_nettype wire

// ===== src/address_region_table_with_locks_top.sv =====
// ----------------------------------------------------------------------------
// address_region_table_with_locks_top
// region table with per-region write locks, scanned one slot per cycle
// ----------------------------------------------------------------------------
//
//   channel   ports                     handshake
//   -------   -----------------------   ------------------------------------
//   request   start, busy, req_item     taken when start high and busy low
//   response  rsp_strobe, rsp_item      valid for one cycle, no back-pressure
//
// an insert or lookup on a non-empty table scans until a hit or the last
// stored slot; release, flush and empty-table requests skip the scan
// the scan reads one slot per cycle from the region memory through the
// single compare unit, inserts scan upwards, lookups scan downwards
// the response appears in the cycle in which busy falls again
// synchronous reset empties the table and clears all locks at once
//
`default_nettype none

`include "assert_macros.svh"

module address_region_table_with_locks_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  artl_pkg::req_type req_item,
   output logic              rsp_strobe,
   output artl_pkg::rsp_type rsp_item
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DONE
   } state_type;

   state_type                       state_ff, state_in;
   artl_pkg::req_type               req_ff, req_in;
   logic [63:0]                     top_ff, top_in;
   logic [artl_pkg::SlotW-1:0]      ptr_ff, ptr_in;
   logic                            hit_ff, hit_in;
   logic [artl_pkg::SlotW-1:0]      hit_slot_ff, hit_slot_in;
   logic signed [31:0]              hit_index_ff, hit_index_in;
   logic [artl_pkg::CountW-1:0]     count_ff, count_in;
   logic [artl_pkg::MaxRegions-1:0] locks_ff, locks_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   artl_pkg::rsp_type               rsp_ff, rsp_in;

   artl_pkg::entry_type             mem [artl_pkg::MaxRegions];
   artl_pkg::entry_type             rd_data_ff;
   artl_pkg::entry_type             wr_entry;
   logic                            wr_en;
   logic [artl_pkg::SlotW-1:0]      wr_slot;
   logic [artl_pkg::SlotW-1:0]      last_slot;
   logic [artl_pkg::SlotW-1:0]      rel_slot;
   artl_pkg::match_type             match;
   logic                            scan_hit;
   logic                            scan_last;

   // shared compare unit
   artl_match u_match (
      .entry          (rd_data_ff),
      .key_index      (req_ff.region_index),
      .access_address (req_ff.access_address),
      .access_top     (top_ff),
      .result         (match)
   );

   // slot helpers
   assign wr_slot   = artl_pkg::SlotW'(count_ff);
   assign last_slot = artl_pkg::SlotW'(count_ff - artl_pkg::CountW'(1));
   assign rel_slot  = artl_pkg::SlotW'(req_ff.release_slot);
   assign wr_entry  = '{index: req_ff.region_index, base: req_ff.region_base,
                        length: req_ff.region_length};

   // scan hit and end of scan, by direction
   always_comb begin
      if (req_ff.mode == artl_pkg::ModeInsert) begin
         scan_hit  = match.index_hit;
         scan_last = (artl_pkg::CountW'(ptr_ff) == count_ff - artl_pkg::CountW'(1));
      end else begin
         scan_hit  = match.covers;
         scan_last = (ptr_ff == '0);
      end
   end

   // sequencer next values
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      top_in       = top_ff;
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_index_in = hit_index_ff;
      count_in     = count_ff;
      locks_in     = locks_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               req_in = req_item;
               top_in = req_item.access_address + 64'(req_item.access_len);
               hit_in = 1'b0;
               if ((count_ff != '0) && ((req_item.mode == artl_pkg::ModeInsert) ||
                                        (req_item.mode == artl_pkg::ModeLookup))) begin
                  state_in = SCAN;
                  ptr_in   = (req_item.mode == artl_pkg::ModeInsert) ? '0 : last_slot;
               end else begin
                  state_in = DONE;
               end
            end
         end
         SCAN: begin
            if (scan_hit) begin
               hit_in       = 1'b1;
               hit_slot_in  = ptr_ff;
               hit_index_in = rd_data_ff.index;
               state_in     = DONE;
            end else if (scan_last) begin
               state_in = DONE;
            end else if (req_ff.mode == artl_pkg::ModeInsert) begin
               ptr_in = ptr_ff + artl_pkg::SlotW'(1);
            end else begin
               ptr_in = ptr_ff - artl_pkg::SlotW'(1);
            end
         end
         DONE: begin
            state_in     = IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            case (req_ff.mode)
               artl_pkg::ModeInsert: begin
                  if (hit_ff) begin
                     rsp_in.status = artl_pkg::StatusDuplicate;
                  end else if (count_ff >= artl_pkg::CountW'(artl_pkg::MaxRegions)) begin
                     rsp_in.status = artl_pkg::StatusFull;
                  end else begin
                     wr_en             = 1'b1;
                     locks_in[wr_slot] = 1'b0;
                     count_in          = count_ff + artl_pkg::CountW'(1);
                     rsp_in.status     = artl_pkg::StatusOk;
                     rsp_in.slot       = 4'(wr_slot);
                  end
               end
               artl_pkg::ModeLookup: begin
                  if (hit_ff) begin
                     rsp_in.slot          = 4'(hit_slot_ff);
                     rsp_in.matched_index = hit_index_ff;
                     if (locks_ff[hit_slot_ff]) begin
                        rsp_in.status = artl_pkg::StatusBusy;
                     end else begin
                        locks_in[hit_slot_ff] = 1'b1;
                        rsp_in.status         = artl_pkg::StatusOk;
                     end
                  end else begin
                     rsp_in.status = artl_pkg::StatusNone;
                  end
               end
               artl_pkg::ModeRelease: begin
                  if ((32'(req_ff.release_slot) < 32'(count_ff)) && locks_ff[rel_slot]) begin
                     locks_in[rel_slot] = 1'b0;
                     rsp_in.status      = artl_pkg::StatusOk;
                  end else begin
                     rsp_in.status = artl_pkg::StatusUnlocked;
                  end
               end
               default: begin
                  // flush
                  count_in      = '0;
                  locks_in      = '0;
                  rsp_in.status = artl_pkg::StatusOk;
               end
            endcase
         end
         default: state_in = IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         locks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         locks_ff     <= locks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      top_ff       <= top_in;
      ptr_ff       <= ptr_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_index_ff <= hit_index_in;
      rsp_ff       <= rsp_in;
   end

   // region memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_entry;
      end
      rd_data_ff <= mem[ptr_in];
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // checks
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= artl_pkg::CountW'(artl_pkg::MaxRegions), "entry count beyond table size")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == DONE, rsp_strobe && !busy, "response missing after completion")
   `ASSERT_IMPLY(a_hit_in_range, clock, reset, (state_ff == DONE) && hit_ff, artl_pkg::CountW'(hit_slot_ff) < count_ff, "matched slot outside table")
   `ASSERT_NEXT(a_flush_clears, clock, reset, (state_ff == DONE) && (req_ff.mode == artl_pkg::ModeFlush), (count_ff == '0) && (locks_ff == '0), "flush left entries or locks")

endmodule

`default_nettype wire
